// ===== rtl/assert_macros.svh =====
// Assertion macros used by the equalizer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// ===== rtl/sbqeq_pkg.sv =====
// Types, constants and rounding function for the stereo biquad equalizer.
package sbqeq_pkg;

  localparam int STAGES         = 8;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 24;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 3;
  localparam int COEF_WORDS     = STAGES * 5;
  localparam int ROWS           = STAGES * 2;
  localparam int STAGE_BITS     = $clog2(STAGES);
  localparam int ROW_BITS       = $clog2(ROWS);
  localparam int CADDR_BITS     = $clog2(COEF_WORDS);
  localparam int CADDR_PORT     = 6;
  localparam int NCNT_BITS      = 4;
  localparam int CFG_DATA_BITS  = 4;
  localparam int CFG_IDX_BITS   = 2;
  localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_BITS       = PROD_BITS + 3;
  localparam int RND_BITS       = ACC_BITS - COEF_FRAC_BITS;
  localparam int ROW_WIDTH      = 4 * SAMPLE_BITS;
  localparam int K_BITS         = 3;

  localparam logic [K_BITS-1:0] K_FIRST = K_BITS'(0);
  localparam logic [K_BITS-1:0] K_SUB   = K_BITS'(3);
  localparam logic [K_BITS-1:0] K_LAST  = K_BITS'(4);

  localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_STAGES = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_MONO   = CFG_IDX_BITS'(2);

  localparam logic signed [RND_BITS-1:0] RND_MAX = RND_BITS'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
  localparam logic signed [RND_BITS-1:0] RND_MIN = -RND_MAX - RND_BITS'(1);
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0] RND_HALF = ACC_BITS'(64'd1 << (COEF_FRAC_BITS-1));

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_COEF   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_ROUND,
    ST_WRITE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic sub;
    logic last;
  } mac_ctrl_t;

  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [ACC_BITS-1:0] acc
  );
    logic signed [ACC_BITS-1:0] u;
    logic signed [RND_BITS-1:0] r;
    u = acc + RND_HALF;
    r = u[ACC_BITS-1:COEF_FRAC_BITS];
    if (r > RND_MAX) begin
      return SMP_MAX;
    end else if (r < RND_MIN) begin
      return SMP_MIN;
    end else begin
      return r[SAMPLE_BITS-1:0];
    end
  endfunction

endpackage

// ===== rtl/stereo_biquad_cascade_eq_unit.sv =====
// Top level of the stereo cascaded biquad equalizer.
//
//   port group | direction | handshake          | content
//   in_        | input     | in_valid/in_ready   | cmd, samples, coefficient address/value
//   out_       | output    | out_valid/out_ready | filtered left/right samples
//   cfg_       | input     | cfg_wr_en           | enable, stage count, mono select
//
// A filtered sample pair runs each of the N active sections, left then right,
// on the single MAC, which paces the work with the history memory (one row
// address) and the coefficient read port (5 reads, 3-stage drain, round,
// write back). Bypassed pairs, coefficient writes and clears skip the MAC.
// Reset is synchronous; it empties all histories at once through row valid bits.
// A stalled result sits in the output register while the next item enters.
module stereo_biquad_cascade_eq_unit (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [1:0]                                     in_cmd,
  input  logic signed [sbqeq_pkg::SAMPLE_BITS-1:0]       in_left_in,
  input  logic signed [sbqeq_pkg::SAMPLE_BITS-1:0]       in_right_in,
  input  logic [sbqeq_pkg::CADDR_PORT-1:0]               in_coef_address,
  input  logic signed [sbqeq_pkg::COEF_BITS-1:0]         in_coef_value,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic signed [sbqeq_pkg::SAMPLE_BITS-1:0]       out_left_out,
  output logic signed [sbqeq_pkg::SAMPLE_BITS-1:0]       out_right_out,
  input  logic                                           cfg_wr_en,
  input  logic [sbqeq_pkg::CFG_IDX_BITS-1:0]             cfg_index,
  input  logic [sbqeq_pkg::CFG_DATA_BITS-1:0]            cfg_data
);
  import sbqeq_pkg::*;
  `include "assert_macros.svh"

  state_t                         state_r;
  state_t                         state_nxt;
  logic                           filter_enable_r;
  logic [NCNT_BITS-1:0]           active_stages_r;
  logic                           mono_input_r;
  logic [NCNT_BITS-1:0]           n_stages;

  logic [STAGE_BITS-1:0]          s_r;
  logic                           ch_r;
  logic [K_BITS-1:0]              k_r;
  logic signed [SAMPLE_BITS-1:0]  samp_r [2];
  logic signed [SAMPLE_BITS-1:0]  x;
  logic signed [SAMPLE_BITS-1:0]  y_r;
  logic signed [SAMPLE_BITS-1:0]  h_r [4];

  logic signed [COEF_BITS-1:0]    coef_mem [COEF_WORDS];
  logic signed [COEF_BITS-1:0]    coef_q_r;
  logic [CADDR_BITS-1:0]          coef_raddr;
  logic [ROW_WIDTH-1:0]           hist_mem [ROWS];
  logic [ROW_WIDTH-1:0]           hist_q_r;
  logic [ROWS-1:0]                hist_vld_r;
  logic                           hist_vq_r;
  logic [ROW_BITS-1:0]            row;

  logic                           rd_vld_r;
  logic [K_BITS-1:0]              rd_k_r;
  mac_ctrl_t                      mac_ctrl;
  logic signed [SAMPLE_BITS-1:0]  mac_op;
  logic signed [ACC_BITS-1:0]     mac_acc;
  logic                           mac_done;

  logic                           in_fire;
  logic                           sample_go;
  logic                           last_step;
  logic                           hist_we;
  logic                           out_load;
  logic                           out_valid_r;
  logic signed [SAMPLE_BITS-1:0]  out_left_r;
  logic signed [SAMPLE_BITS-1:0]  out_right_r;

  assign n_stages  = (active_stages_r > NCNT_BITS'(STAGES)) ? NCNT_BITS'(STAGES)
                                                              : active_stages_r;
  assign row       = {s_r, ch_r};
  assign x         = samp_r[ch_r];
  assign coef_raddr = CADDR_BITS'({s_r, 2'b00}) + CADDR_BITS'(s_r) + CADDR_BITS'(k_r);
  assign in_fire   = in_valid && in_ready;
  assign sample_go = filter_enable_r && (n_stages != '0);
  assign last_step = ch_r && ((NCNT_BITS'(s_r) + NCNT_BITS'(1)) == n_stages);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_enable_r <= 1'b0;
      active_stages_r <= '0;
      mono_input_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ENABLE: filter_enable_r <= cfg_data[0];
        CFG_STAGES: active_stages_r <= cfg_data;
        CFG_MONO:   mono_input_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_cmd == CMD_SAMPLE)) begin
          state_nxt = sample_go ? ST_ISSUE : ST_OUT;
        end
      end
      ST_ISSUE: begin
        if (k_r == K_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = last_step ? ST_OUT : ST_ISSUE;
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    hist_we  = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_WRITE: hist_we  = 1'b1;
      ST_OUT:   out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      s_r        <= '0;
      ch_r       <= 1'b0;
      k_r        <= '0;
      rd_vld_r   <= 1'b0;
      hist_vld_r <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == ST_ISSUE);
      if (state_r == ST_ISSUE) begin
        k_r <= (k_r == K_LAST) ? K_FIRST : k_r + K_BITS'(1);
      end
      if (in_fire && (in_cmd == CMD_SAMPLE)) begin
        s_r  <= '0;
        ch_r <= 1'b0;
        k_r  <= K_FIRST;
      end
      if (in_fire && (in_cmd == CMD_CLEAR)) begin
        hist_vld_r <= '0;
      end
      if (hist_we) begin
        hist_vld_r[row] <= 1'b1;
        ch_r            <= !ch_r;
        if (ch_r) begin
          s_r <= s_r + STAGE_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_k_r <= k_r;
    if (in_fire && (in_cmd == CMD_SAMPLE)) begin
      samp_r[0] <= in_left_in;
      samp_r[1] <= mono_input_r ? in_left_in : in_right_in;
    end
    if (hist_we) begin
      samp_r[ch_r] <= y_r;
    end
    if (state_r == ST_ROUND) begin
      y_r <= round_sat(mac_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_cmd == CMD_COEF) &&
        (in_coef_address < CADDR_PORT'(COEF_WORDS))) begin
      coef_mem[in_coef_address[CADDR_BITS-1:0]] <= in_coef_value;
    end
    coef_q_r <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[row] <= {h_r[2], y_r, h_r[0], x};
    end
    hist_q_r  <= hist_mem[row];
    hist_vq_r <= hist_vld_r[row];
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r && (rd_k_r == K_FIRST)) begin
      for (int i = 0; i < 4; i++) begin
        h_r[i] <= hist_vq_r ? hist_q_r[i*SAMPLE_BITS +: SAMPLE_BITS] : '0;
      end
    end
  end

  always_comb begin
    case (rd_k_r)
      3'd0:    mac_op = x;
      3'd1:    mac_op = h_r[0];
      3'd2:    mac_op = h_r[1];
      3'd3:    mac_op = h_r[2];
      3'd4:    mac_op = h_r[3];
      default: mac_op = x;
    endcase
    mac_ctrl.vld   = rd_vld_r;
    mac_ctrl.first = (rd_k_r == K_FIRST);
    mac_ctrl.sub   = (rd_k_r >= K_SUB);
    mac_ctrl.last  = (rd_k_r == K_LAST);
  end

  sbqeq_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (mac_ctrl),
    .coef_i (coef_q_r),
    .op_i   (mac_op),
    .acc_o  (mac_acc),
    .done_o (mac_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r  <= samp_r[0];
      out_right_r <= samp_r[1];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

  `ASSERT_NEXT(a_bypass_to_out, clk, rst_n, in_fire && (in_cmd == CMD_SAMPLE) && !sample_go, state_r == ST_OUT, "bypassed item did not go to output")
  `ASSERT_IMPLY(a_stage_in_range, clk, rst_n, state_r == ST_ISSUE, NCNT_BITS'(s_r) < n_stages, "section index beyond active count")
  `ASSERT_IMPLY(a_round_after_done, clk, rst_n, state_r == ST_ROUND, $past(mac_done), "rounding before accumulation finished")
  `ASSERT_NEXT(a_write_marks_row, clk, rst_n, hist_we && !in_fire, hist_vld_r[$past(row)], "written history row not marked valid")

endmodule

// ===== rtl/sbqeq_mac.sv =====
// Shared multiply-accumulate unit for the biquad sections.
module sbqeq_mac (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  sbqeq_pkg::mac_ctrl_t                          ctrl_i,
  input  logic signed [sbqeq_pkg::COEF_BITS-1:0]        coef_i,
  input  logic signed [sbqeq_pkg::SAMPLE_BITS-1:0]      op_i,
  output logic signed [sbqeq_pkg::ACC_BITS-1:0]         acc_o,
  output logic                                          done_o
);
  import sbqeq_pkg::*;

  mac_ctrl_t                     ctrl_r;
  logic signed [PROD_BITS-1:0]   prod_r;
  logic signed [ACC_BITS-1:0]    acc_r;
  logic signed [ACC_BITS-1:0]    acc_nxt;
  logic signed [ACC_BITS-1:0]    prod_ext;
  logic signed [ACC_BITS-1:0]    base;
  logic                          done_r;

  always_ff @(posedge clk) begin
    prod_r <= coef_i * op_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctrl_r <= ctrl_i;
      done_r <= ctrl_r.vld && ctrl_r.last;
    end
  end

  always_comb begin
    prod_ext = {{(ACC_BITS-PROD_BITS){prod_r[PROD_BITS-1]}}, prod_r};
    base     = ctrl_r.first ? '0 : acc_r;
    acc_nxt  = ctrl_r.sub ? (base - prod_ext) : (base + prod_ext);
  end

  always_ff @(posedge clk) begin
    if (ctrl_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_o  = acc_r;
  assign done_o = done_r;

endmodule

// ===== tb/tb_stereo_biquad_cascade_eq_unit.sv =====
// Self-checking testbench for the stereo biquad cascade equalizer, directed table then random.
module tb_stereo_biquad_cascade_eq_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sbqeq_pkg::*;

  localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam int A1_SLOT       = 3;
  localparam int A2_SLOT       = 4;
  localparam int SETTLE_CYCLES = 2 + 20 * STAGES + 40;
  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_ITEMS   = 120;
  localparam int HOLD_AFTER    = 300;
  localparam int HOLD_CYCLES   = 600;
  localparam int QUIET_CYCLES  = 300;
  localparam int DIR_ROWS      = 25;

  typedef struct packed {
    cmd_t                          cmd;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic [CADDR_PORT-1:0]         addr;
    logic signed [COEF_BITS-1:0]   coef;
  } eq_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } stereo_pair_t;

  typedef struct packed {
    logic                          en;
    logic [NCNT_BITS-1:0]          stages;
    logic                          mono;
    eq_item_t                      item;
    logic                          typed;
    logic signed [SAMPLE_BITS-1:0] exp_left;
    logic signed [SAMPLE_BITS-1:0] exp_right;
  } eq_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  cmd_t                          in_cmd;
  logic signed [SAMPLE_BITS-1:0] in_left_in;
  logic signed [SAMPLE_BITS-1:0] in_right_in;
  logic [CADDR_PORT-1:0]         in_coef_address;
  logic signed [COEF_BITS-1:0]   in_coef_value;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [SAMPLE_BITS-1:0] out_left_out;
  logic signed [SAMPLE_BITS-1:0] out_right_out;
  logic                          cfg_wr_en;
  logic [CFG_IDX_BITS-1:0]       cfg_index;
  logic [CFG_DATA_BITS-1:0]      cfg_data;

  stereo_biquad_cascade_eq_unit DUT (.*);

  logic signed [COEF_BITS-1:0]   coef_bank [COEF_WORDS];
  logic signed [SAMPLE_BITS-1:0] biquad_hist [STAGES][2][4];
  logic                          eq_enable;
  logic [NCNT_BITS-1:0]          eq_stages;
  logic                          eq_mono;

  stereo_pair_t filtered_q [$];
  int           fail_count  = 0;
  int           pairs_taken = 0;
  int           cycle_count = 0;
  int           gap_odds    = 0;
  bit           calm        = 1'b0;

  eq_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, 4'd0, 1'b0, '{CMD_SAMPLE, SMP_MAX, SMP_MIN, 6'd0, 27'sd0}, 1'b1, SMP_MAX, SMP_MIN},
    '{1'b0, 4'd0, 1'b0, '{CMD_SAMPLE, SMP_MIN, SMP_MAX, 6'd0, 27'sd0}, 1'b1, SMP_MIN, SMP_MAX},
    '{1'b0, 4'd0, 1'b0, '{CMD_SAMPLE, 24'sd0, -24'sd1, 6'd0, 27'sd0}, 1'b1, 24'sd0, -24'sd1},
    '{1'b0, 4'd0, 1'b0, '{CMD_NONE, -24'sd1, SMP_MIN, 6'd63, COEF_MIN}, 1'b0, 24'sd0, 24'sd0},
    '{1'b0, 4'd0, 1'b0, '{CMD_COEF, 24'sd0, 24'sd0, 6'(COEF_WORDS), COEF_MIN}, 1'b0, 24'sd0,
      24'sd0},
    '{1'b0, 4'd0, 1'b0, '{CMD_COEF, 24'sd0, 24'sd0, 6'd63, COEF_MAX}, 1'b0, 24'sd0, 24'sd0},
    '{1'b0, 4'd0, 1'b0, '{CMD_CLEAR, 24'sd0, 24'sd0, 6'd0, 27'sd0}, 1'b0, 24'sd0, 24'sd0},
    '{1'b0, 4'd0, 1'b1, '{CMD_SAMPLE, 24'sd1234567, -24'sd7654321, 6'd0, 27'sd0}, 1'b1,
      24'sd1234567, 24'sd1234567},
    '{1'b0, 4'd0, 1'b1, '{CMD_SAMPLE, SMP_MIN, SMP_MAX, 6'd0, 27'sd0}, 1'b1, SMP_MIN, SMP_MIN},
    '{1'b1, 4'd8, 1'b0, '{CMD_SAMPLE, SMP_MAX, SMP_MIN, 6'd0, 27'sd0}, 1'b0, 24'sd0, 24'sd0},
    '{1'b1, 4'd8, 1'b0, '{CMD_SAMPLE, SMP_MIN, SMP_MAX, 6'd0, 27'sd0}, 1'b0, 24'sd0, 24'sd0},
    '{1'b1, 4'd8, 1'b0, '{CMD_SAMPLE, 24'sd0, 24'sd0, 6'd0, 27'sd0}, 1'b0, 24'sd0, 24'sd0},
    '{1'b1, 4'd8, 1'b0, '{CMD_CLEAR, 24'sd0, 24'sd0, 6'd0, 27'sd0}, 1'b0, 24'sd0, 24'sd0},
    '{1'b1, 4'd8, 1'b0, '{CMD_SAMPLE, SMP_MAX, SMP_MAX, 6'd0, 27'sd0}, 1'b0, 24'sd0, 24'sd0},
    '{1'b1, 4'd8, 1'b0, '{CMD_COEF, 24'sd0, 24'sd0, 6'd0, COEF_MAX}, 1'b0, 24'sd0, 24'sd0},
    '{1'b1, 4'd8, 1'b0, '{CMD_COEF, 24'sd0, 24'sd0, 6'(COEF_WORDS - 1), COEF_MIN}, 1'b0, 24'sd0,
      24'sd0},
    '{1'b1, 4'd8, 1'b0, '{CMD_SAMPLE, SMP_MIN, SMP_MIN, 6'd0, 27'sd0}, 1'b0, 24'sd0, 24'sd0},
    '{1'b1, 4'd8, 1'b0, '{CMD_SAMPLE, SMP_MAX, SMP_MIN, 6'd0, 27'sd0}, 1'b0, 24'sd0, 24'sd0},
    '{1'b1, 4'd15, 1'b1, '{CMD_SAMPLE, 24'sd4194304, -24'sd1, 6'd0, 27'sd0}, 1'b0, 24'sd0,
      24'sd0},
    '{1'b1, 4'd15, 1'b1, '{CMD_SAMPLE, SMP_MIN, 24'sd0, 6'd0, 27'sd0}, 1'b0, 24'sd0, 24'sd0},
    '{1'b1, 4'd0, 1'b0, '{CMD_SAMPLE, SMP_MAX, SMP_MIN, 6'd0, 27'sd0}, 1'b1, SMP_MAX, SMP_MIN},
    '{1'b1, 4'd1, 1'b0, '{CMD_SAMPLE, 24'sd100000, -24'sd100000, 6'd0, 27'sd0}, 1'b0, 24'sd0,
      24'sd0},
    '{1'b1, 4'd1, 1'b0, '{CMD_NONE, 24'sd0, 24'sd0, 6'd0, 27'sd0}, 1'b0, 24'sd0, 24'sd0},
    '{1'b1, 4'd1, 1'b0, '{CMD_SAMPLE, -24'sd1, 24'sd1, 6'd0, 27'sd0}, 1'b0, 24'sd0, 24'sd0},
    '{1'b1, 4'd1, 1'b0, '{CMD_CLEAR, 24'sd0, 24'sd0, 6'd0, 27'sd0}, 1'b0, 24'sd0, 24'sd0}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [SAMPLE_BITS-1:0] biquad_section(
    input int s, input int ch, input logic signed [SAMPLE_BITS-1:0] x
  );
    longint acc;
    longint q;
    logic signed [SAMPLE_BITS-1:0] y;
    acc = longint'(coef_bank[s*5])   * longint'(x)
        + longint'(coef_bank[s*5+1]) * longint'(biquad_hist[s][ch][0])
        + longint'(coef_bank[s*5+2]) * longint'(biquad_hist[s][ch][1])
        - longint'(coef_bank[s*5+3]) * longint'(biquad_hist[s][ch][2])
        - longint'(coef_bank[s*5+4]) * longint'(biquad_hist[s][ch][3]);
    q = (acc + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    if (q > longint'(SMP_MAX)) begin
      y = SMP_MAX;
    end else if (q < longint'(SMP_MIN)) begin
      y = SMP_MIN;
    end else begin
      y = q[SAMPLE_BITS-1:0];
    end
    biquad_hist[s][ch][1] = biquad_hist[s][ch][0];
    biquad_hist[s][ch][0] = x;
    biquad_hist[s][ch][3] = biquad_hist[s][ch][2];
    biquad_hist[s][ch][2] = y;
    return y;
  endfunction

  function automatic stereo_pair_t equalize_pair(
    input logic signed [SAMPLE_BITS-1:0] l, input logic signed [SAMPLE_BITS-1:0] r
  );
    stereo_pair_t p;
    int n;
    p.left  = l;
    p.right = eq_mono ? l : r;
    if (eq_enable) begin
      n = (eq_stages > STAGES) ? STAGES : int'(eq_stages);
      for (int s = 0; s < n; s++) begin
        p.left  = biquad_section(s, 0, p.left);
        p.right = biquad_section(s, 1, p.right);
      end
    end
    return p;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2, 3: return SAMPLE_BITS'($urandom_range(0, 8192)) - SAMPLE_BITS'(4096);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  // keep a1/a2 inside the stability triangle so the cascade does not just rail
  function automatic logic signed [COEF_BITS-1:0] tame_coef(input int k);
    int v;
    case (k)
      A1_SLOT: v = int'($urandom_range(0, 30198988)) - 15099494;
      A2_SLOT: v = int'($urandom_range(0, 14260634)) - 838861;
      default: v = int'($urandom_range(0, 33554432)) - 16777216;
    endcase
    return COEF_BITS'(v);
  endfunction

  function automatic eq_item_t random_item();
    eq_item_t it;
    int pick;
    pick     = $urandom_range(0, 99);
    it.left  = rand_sample();
    it.right = rand_sample();
    it.addr  = CADDR_PORT'($urandom_range(0, COEF_WORDS - 1));
    it.coef  = COEF_BITS'($urandom());
    if (pick < 84) begin
      it.cmd = CMD_SAMPLE;
    end else if (pick < 90) begin
      it.cmd = CMD_COEF;
      if ($urandom_range(0, 3) != 0) it.coef = tame_coef(int'(it.addr) % 5);
    end else if (pick < 93) begin
      it.cmd  = CMD_COEF;
      it.addr = CADDR_PORT'($urandom_range(COEF_WORDS, 63));
    end else if (pick < 96) begin
      it.cmd = CMD_CLEAR;
    end else begin
      it.cmd  = CMD_NONE;
      it.addr = CADDR_PORT'($urandom_range(0, 63));
    end
    return it;
  endfunction

  task automatic push_item(
    input eq_item_t it, input bit typed, input stereo_pair_t typed_pair
  );
    stereo_pair_t pair;
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= it.cmd;
    in_left_in      <= it.left;
    in_right_in     <= it.right;
    in_coef_address <= it.addr;
    in_coef_value   <= it.coef;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (it.cmd)
      CMD_SAMPLE: begin
        pair = equalize_pair(it.left, it.right);
        filtered_q.push_back(typed ? typed_pair : pair);
      end
      CMD_COEF: begin
        if (it.addr < COEF_WORDS) coef_bank[it.addr] = it.coef;
      end
      CMD_CLEAR: begin
        foreach (biquad_hist[s, c, k]) biquad_hist[s][c][k] = '0;
      end
      default: ;
    endcase
  endtask

  task automatic load_coef_bank(input bit wild);
    eq_item_t it;
    for (int a = 0; a < COEF_WORDS; a++) begin
      it       = random_item();
      it.cmd   = CMD_COEF;
      it.addr  = CADDR_PORT'(a);
      it.coef  = wild ? COEF_BITS'($urandom()) : tame_coef(a % 5);
      push_item(it, 1'b0, '0);
    end
  endtask

  // drop valid, drain all pending pairs, then let any trailing command finish
  task automatic settle();
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(
    input logic en, input logic [NCNT_BITS-1:0] stg, input logic mono
  );
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ENABLE;
    cfg_data  <= CFG_DATA_BITS'(en);
    @(posedge clk);
    eq_enable = en;
    cfg_index <= CFG_STAGES;
    cfg_data  <= CFG_DATA_BITS'(stg);
    @(posedge clk);
    eq_stages = stg;
    cfg_index <= CFG_MONO;
    cfg_data  <= CFG_DATA_BITS'(mono);
    @(posedge clk);
    eq_mono = mono;
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    eq_item_t     it;
    stereo_pair_t typed_pair;
    int           done;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_cmd          <= CMD_NONE;
    in_left_in      <= '0;
    in_right_in     <= '0;
    in_coef_address <= '0;
    in_coef_value   <= '0;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= CFG_ENABLE;
    cfg_data        <= '0;
    eq_enable = 1'b0;
    eq_stages = '0;
    eq_mono   = 1'b0;
    foreach (coef_bank[a]) coef_bank[a] = '0;
    foreach (biquad_hist[s, c, k]) biquad_hist[s][c][k] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    gap_odds = 4;
    load_coef_bank(1'b0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].en != eq_enable || dir_rows[i].stages != eq_stages ||
          dir_rows[i].mono != eq_mono) begin
        settle();
        program_regs(dir_rows[i].en, dir_rows[i].stages, dir_rows[i].mono);
      end
      typed_pair.left  = dir_rows[i].exp_left;
      typed_pair.right = dir_rows[i].exp_right;
      push_item(dir_rows[i].item, dir_rows[i].typed, typed_pair);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      case (p)
        0: program_regs(1'b1, 4'd8, 1'b0);
        1: program_regs(1'b0, NCNT_BITS'($urandom_range(0, 15)), 1'b1);
        2: program_regs(1'b1, 4'd15, 1'($urandom_range(0, 1)));
        3: program_regs(1'b1, 4'd0, 1'b1);
        default: program_regs(1'($urandom_range(0, 5) != 0), NCNT_BITS'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)));
      endcase
      case ($urandom_range(0, 3))
        0: gap_odds = 0;
        1: gap_odds = 2;
        2: gap_odds = 4;
        default: gap_odds = 8;
      endcase
      calm = (p == RAND_PHASES - 1);
      if (p == 0 || $urandom_range(0, 1) == 1) begin
        load_coef_bank(p != 0 && $urandom_range(0, 4) == 0);
      end
      done = 0;
      while (done < PHASE_ITEMS) begin
        it = random_item();
        push_item(it, 1'b0, '0);
        if (!(it.cmd == CMD_NONE || (it.cmd == CMD_COEF && it.addr >= COEF_WORDS))) done++;
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("stereo_biquad_cascade_eq_unit verification clean");
    end else begin
      $display("stereo_biquad_cascade_eq_unit verification failed");
    end
    $finish;
  end

  initial begin : out_pacing
    bit held_long;
    held_long = 1'b0;
    forever begin
      if (!held_long && pairs_taken >= HOLD_AFTER) begin
        held_long = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else if ($urandom_range(0, 49) == 0) begin
        out_ready <= 1'b1;
        repeat (QUIET_CYCLES) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : pair_check
    stereo_pair_t want;
    if (rst_n && out_valid && out_ready) begin
      pairs_taken++;
      if (filtered_q.size() == 0) begin
        fail_count++;
        $error("unexpected out item: left_out %0d, right_out %0d", out_left_out, out_right_out);
      end else begin
        want = filtered_q.pop_front();
        if (out_left_out !== want.left) begin
          fail_count++;
          $error("left_out: expected %0d, got %0d", want.left, out_left_out);
        end
        if (out_right_out !== want.right) begin
          fail_count++;
          $error("right_out: expected %0d, got %0d", want.right, out_right_out);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("stereo_biquad_cascade_eq_unit verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sbqeq_pkg.sv
rtl/sbqeq_mac.sv
rtl/stereo_biquad_cascade_eq_unit.sv
tb/tb_stereo_biquad_cascade_eq_unit.sv
